/* design/ljhs_pkg.sv */
// ----------------------------------------------------------------------------
// ljhs_pkg
// Shared widths, constants and control structs of the late job heap scheduler.
// ----------------------------------------------------------------------------
package ljhs_pkg;

    localparam int DL_W      = 16;
    localparam int LEN_W     = 16;
    localparam int RATE_W    = 32;
    localparam int LATE_W    = 11;
    localparam int TOTAL_W   = 26;
    localparam int NEED_W    = TOTAL_W + 1;
    localparam int BUDGET_W  = RATE_W + DL_W;
    localparam int IN_W      = DL_W + LEN_W;
    localparam int OUT_W     = 40;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 32;

    localparam logic [LATE_W-1:0] LATE_MAX = 11'd2047;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_RATE  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 1'b1;

    typedef struct packed {
        logic             valid;
        logic             push;
        logic [LEN_W-1:0] value;
    } t_heap_cmd;

    typedef struct packed {
        logic             busy;
        logic [LEN_W-1:0] top;
    } t_heap_stat;

endpackage

/* design/ljhs_ram.sv */
// ----------------------------------------------------------------------------
// ljhs_ram
// Generic RAM, one write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module ljhs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    output logic [WIDTH-1:0]         o_rdata_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

/* design/ljhs_heap.sv */
// ----------------------------------------------------------------------------
// ljhs_heap
// Max-heap of job lengths in RAM: sift-up insert and sift-down replace of the
// top, one heap level per cycle, with a register copy of the top entry.
// ----------------------------------------------------------------------------
module ljhs_heap #(
    parameter int HEAP_DEPTH = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  ljhs_pkg::t_heap_cmd                 i_cmd,
    input  logic [$clog2(HEAP_DEPTH+1)-1:0]     i_count,
    output ljhs_pkg::t_heap_stat                o_stat
);
    import ljhs_pkg::*;

    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);

    logic             r_busy, n_busy;
    logic             r_push;
    logic [LEN_W-1:0] r_val;
    logic [AW-1:0]    r_idx, n_idx;
    logic [CW-1:0]    r_cnt;
    logic [LEN_W-1:0] r_top;

    logic             w_we;
    logic [AW-1:0]    w_waddr;
    logic [LEN_W-1:0] w_wdata;
    logic [AW-1:0]    w_raddr_a, w_raddr_b;
    logic [LEN_W-1:0] w_rdata_a, w_rdata_b;
    logic             w_next_push;

    logic [CW:0]      w_child;
    logic             w_left_ok, w_right_ok, w_pick_r;
    logic [LEN_W-1:0] w_cval;
    logic [AW-1:0]    w_cidx;
    logic [AW-1:0]    w_parent;

    ljhs_ram #(
        .WIDTH (LEN_W),
        .DEPTH (HEAP_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_raddr_a (w_raddr_a),
        .o_rdata_a (w_rdata_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_b (w_rdata_b)
    );

    // children of the current slot for sift-down, parent for sift-up
    assign w_child    = ((CW+1)'(r_idx) << 1) | (CW+1)'(1);
    assign w_left_ok  = w_child < {1'b0, r_cnt};
    assign w_right_ok = (w_child + (CW+1)'(1)) < {1'b0, r_cnt};
    assign w_pick_r   = w_right_ok && (w_rdata_b > w_rdata_a);
    assign w_cval     = w_pick_r ? w_rdata_b : w_rdata_a;
    assign w_cidx     = AW'(w_child) + AW'(w_pick_r);
    assign w_parent   = (r_idx - AW'(1)) >> 1;

    always_comb begin
        n_busy  = r_busy;
        n_idx   = r_idx;
        w_we    = 1'b0;
        w_waddr = r_idx;
        w_wdata = r_val;
        if (!r_busy) begin
            if (i_cmd.valid) begin
                if (i_cmd.push) begin
                    if (i_count == '0) begin
                        w_we    = 1'b1;
                        w_waddr = '0;
                        w_wdata = i_cmd.value;
                    end else begin
                        n_busy = 1'b1;
                        n_idx  = AW'(i_count);
                    end
                end else begin
                    n_busy = 1'b1;
                    n_idx  = '0;
                end
            end
        end else if (r_push) begin
            w_we = 1'b1;
            if (r_idx == '0 || w_rdata_a >= r_val) begin
                n_busy = 1'b0;
            end else begin
                w_wdata = w_rdata_a;
                n_idx   = w_parent;
            end
        end else begin
            w_we = 1'b1;
            if (!w_left_ok || w_cval <= r_val) begin
                n_busy = 1'b0;
            end else begin
                w_wdata = w_cval;
                n_idx   = w_cidx;
            end
        end
    end

    assign w_next_push = r_busy ? r_push : i_cmd.push;
    assign w_raddr_a   = w_next_push ? AW'((n_idx - AW'(1)) >> 1) : AW'({n_idx, 1'b1});
    assign w_raddr_b   = AW'({n_idx, 1'b0} + (AW+1)'(2));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else begin
            r_busy <= n_busy;
        end
        r_idx <= n_idx;
        if (!r_busy && i_cmd.valid) begin
            r_push <= i_cmd.push;
            r_val  <= i_cmd.value;
            r_cnt  <= i_count;
        end
        if (w_we && w_waddr == '0) begin
            r_top <= w_wdata;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.top  = r_top;

endmodule

/* design/late_job_heap_scheduler.sv */
// ----------------------------------------------------------------------------
// late_job_heap_scheduler
// Late-job feasibility pass: budget check per job, max-heap of accepted job
// lengths in RAM, running total, late count and sticky failure.
//
//   channel   dir  handshake                      payload
//   s_axis    in   s_axis_tvalid / s_axis_tready  tdata deadline, job_length;
//                                                 tuser first; tlast last
//   m_axis    out  m_axis_tvalid / m_axis_tready  tdata feasible, late_jobs,
//                                                 accepted_total, heap_overflow;
//                                                 tlast run_end
//   cfg       in   i_cfg_valid / o_cfg_ready      index, data
//
// a job passes the states accept, multiply rate by deadline, decide and load
// the result register; the heap sift after it runs one level per cycle on the
// RAM read ports, overlapping the next job
// reset clears run state, rate to 1 and limit to 0; heap RAM needs no clearing
// a stalled output holds the next decision, a running sift holds it as well
// ----------------------------------------------------------------------------
module late_job_heap_scheduler #(
    parameter int HEAP_DEPTH = 1024
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [ljhs_pkg::IN_W-1:0]          s_axis_tdata,   // deadline, job_length
    input  logic [0:0]                         s_axis_tuser,   // first
    input  logic                               s_axis_tlast,

    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [ljhs_pkg::OUT_W-1:0]         m_axis_tdata,   // feasible, late_jobs,
                                                               // accepted_total,
                                                               // heap_overflow, pad
    output logic                               m_axis_tlast,

    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ljhs_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [ljhs_pkg::CFG_DAT_W-1:0]     i_cfg_data
);
    import ljhs_pkg::*;

    localparam int CW = $clog2(HEAP_DEPTH + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DEC  = 2'd2;

    logic [1:0]          r_state;
    logic [RATE_W-1:0]   r_rate;
    logic [LATE_W-1:0]   r_limit;
    logic [DL_W-1:0]     r_dl;
    logic [LEN_W-1:0]    r_len;
    logic                r_last;
    logic [BUDGET_W-1:0] r_budget;
    logic [NEED_W-1:0]   r_need;
    logic [CW-1:0]       r_count, n_count;
    logic [TOTAL_W-1:0]  r_total, n_total;
    logic [LATE_W-1:0]   r_late, n_late;
    logic                r_failed, n_failed;
    logic                r_ovf, n_ovf;
    logic                r_out_valid;
    logic [OUT_W-1:0]    r_out_data;
    logic                r_out_last;

    logic                w_accept;
    logic                w_go;
    logic                w_on_time;
    logic [LATE_W-1:0]   w_late_inc;
    logic [BUDGET_W-1:0] w_prod;
    t_heap_cmd           w_cmd;
    t_heap_stat          w_stat;

    ljhs_heap #(
        .HEAP_DEPTH (HEAP_DEPTH)
    ) u_heap (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_count (r_count),
        .o_stat  (w_stat)
    );

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign w_prod    = BUDGET_W'(r_rate) * BUDGET_W'(r_dl);
    assign w_on_time = r_budget >= BUDGET_W'(r_need);
    assign w_go      = (r_state == ST_DEC) && (!r_out_valid || m_axis_tready) && !w_stat.busy;
    assign w_late_inc = (r_late == LATE_MAX) ? r_late : r_late + LATE_W'(1);

    always_comb begin
        n_count     = r_count;
        n_total     = r_total;
        n_late      = r_late;
        n_failed    = r_failed;
        n_ovf       = r_ovf;
        w_cmd.valid = 1'b0;
        w_cmd.push  = 1'b0;
        w_cmd.value = r_len;
        if (!r_failed) begin
            if (w_on_time) begin
                if (r_count >= CW'(HEAP_DEPTH) || r_need[NEED_W-1]) begin
                    n_ovf = 1'b1;
                end else begin
                    n_total     = r_need[TOTAL_W-1:0];
                    n_count     = r_count + CW'(1);
                    w_cmd.valid = w_go;
                    w_cmd.push  = 1'b1;
                end
            end else begin
                n_late = w_late_inc;
                if (w_late_inc > r_limit) begin
                    n_failed = 1'b1;
                end else if (r_count != '0 && w_stat.top > r_len) begin
                    // swap the longest accepted job for the late one
                    n_total     = r_total - TOTAL_W'(w_stat.top) + TOTAL_W'(r_len);
                    w_cmd.valid = w_go;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rate      <= RATE_W'(1);
            r_limit     <= '0;
            r_count     <= '0;
            r_total     <= '0;
            r_late      <= '0;
            r_failed    <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_RATE:  r_rate  <= i_cfg_data;
                    CFG_LIMIT: r_limit <= i_cfg_data[LATE_W-1:0];
                endcase
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= ST_MUL;
                        if (s_axis_tuser[0]) begin
                            r_count  <= '0;
                            r_total  <= '0;
                            r_late   <= '0;
                            r_failed <= 1'b0;
                            r_ovf    <= 1'b0;
                        end
                    end
                end
                ST_MUL: begin
                    r_state <= ST_DEC;
                end
                ST_DEC: begin
                    if (w_go) begin
                        r_state  <= ST_IDLE;
                        r_count  <= n_count;
                        r_total  <= n_total;
                        r_late   <= n_late;
                        r_failed <= n_failed;
                        r_ovf    <= n_ovf;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            if (w_go) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_dl   <= s_axis_tdata[DL_W-1:0];
            r_len  <= s_axis_tdata[IN_W-1:DL_W];
            r_last <= s_axis_tlast;
        end
        if (r_state == ST_MUL) begin
            r_budget <= w_prod;
            r_need   <= NEED_W'(r_total) + NEED_W'(r_len);
        end
        if (w_go) begin
            r_out_data <= {1'b0, n_ovf, n_total, n_late, !n_failed};
            r_out_last <= r_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    a_cmd_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.busy |-> !w_cmd.valid)
        else $error("heap command while sift running");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(HEAP_DEPTH))
        else $error("heap count past depth");

    a_accept_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == ST_MUL))
        else $error("accepted word not sent to multiply");

    a_failed_late: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_failed |-> (r_late != '0))
        else $error("failure without late job");

endmodule

/* tb/ljhs_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ljhs_checker
// Watches the job, result and register channels of the late job heap
// scheduler. Keeps its own heap of accepted lengths, run total, late count
// and sticky flags, predicts one result word per accepted job and compares
// every result word field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module ljhs_checker #(
    parameter int HEAP_DEPTH = 1024
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    input  logic                           i_job_valid,
    input  logic                           i_job_ready,
    input  logic [ljhs_pkg::IN_W-1:0]      i_job_data,
    input  logic [0:0]                     i_job_user,
    input  logic                           i_job_last,

    input  logic                           i_res_valid,
    input  logic                           i_res_ready,
    input  logic [ljhs_pkg::OUT_W-1:0]     i_res_data,
    input  logic                           i_res_last,

    input  logic                           i_cfg_valid,
    input  logic                           i_cfg_ready,
    input  logic [ljhs_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ljhs_pkg::CFG_DAT_W-1:0] i_cfg_data,

    output int                             o_fail_count,
    output int                             o_pending,
    output int                             o_checked
);
    import ljhs_pkg::*;

    localparam logic [63:0] TOTAL_MAX = (64'd1 << TOTAL_W) - 64'd1;

    typedef struct packed {
        logic               feasible;
        logic [LATE_W-1:0]  late_jobs;
        logic [TOTAL_W-1:0] total;
        logic               overflow;
        logic               run_end;
    } t_sched_result;

    logic [RATE_W-1:0]  cfg_rate;
    logic [LATE_W-1:0]  cfg_late_limit;

    logic [LEN_W-1:0]   len_heap [HEAP_DEPTH];
    int                 heap_size;
    logic [TOTAL_W-1:0] run_total;
    logic [LATE_W-1:0]  late_seen;
    logic               run_failed;
    logic               run_overflow;

    t_sched_result      expected_results [$];
    int                 fail_count;
    int                 checked;

    function automatic void heap_insert(logic [LEN_W-1:0] v);
        int i;
        int p;
        i = heap_size;
        heap_size++;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (len_heap[p] >= v) break;
            len_heap[i] = len_heap[p];
            i = p;
        end
        len_heap[i] = v;
    endfunction

    function automatic void heap_replace_top(logic [LEN_W-1:0] v);
        int i;
        int c;
        i = 0;
        while (1) begin
            c = 2 * i + 1;
            if (c >= heap_size) break;
            if (c + 1 < heap_size && len_heap[c + 1] > len_heap[c]) c++;
            if (len_heap[c] <= v) break;
            len_heap[i] = len_heap[c];
            i = c;
        end
        len_heap[i] = v;
    endfunction

    function automatic t_sched_result schedule_job(logic [DL_W-1:0] dl, logic [LEN_W-1:0] len,
                                                   logic is_first, logic is_last);
        logic [63:0]   budget;
        logic [63:0]   need;
        t_sched_result r;
        if (is_first) begin
            heap_size    = 0;
            run_total    = '0;
            late_seen    = '0;
            run_failed   = 1'b0;
            run_overflow = 1'b0;
        end
        if (!run_failed) begin
            budget = 64'(cfg_rate) * 64'(dl);
            need   = 64'(run_total) + 64'(len);
            if (budget >= need) begin
                if (heap_size >= HEAP_DEPTH || need > TOTAL_MAX) begin
                    run_overflow = 1'b1;
                end else begin
                    run_total = need[TOTAL_W-1:0];
                    heap_insert(len);
                end
            end else begin
                if (late_seen < LATE_MAX) late_seen++;
                if (late_seen > cfg_late_limit) begin
                    run_failed = 1'b1;
                end else if (heap_size > 0 && len_heap[0] > len) begin
                    run_total = run_total - len_heap[0] + len;
                    heap_replace_top(len);
                end
            end
        end
        r.feasible  = !run_failed;
        r.late_jobs = late_seen;
        r.total     = run_total;
        r.overflow  = run_overflow;
        r.run_end   = is_last;
        return r;
    endfunction

    function automatic int field_differs(string name, longint unsigned e, longint unsigned a);
        if (e == a) return 0;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, e, a);
        return 1;
    endfunction

    always @(posedge i_clk) begin
        t_sched_result e;
        t_sched_result p;
        int            bad;
        if (!i_rst_n) begin
            cfg_rate       = 32'd1;
            cfg_late_limit = '0;
            heap_size      = 0;
            run_total      = '0;
            late_seen      = '0;
            run_failed     = 1'b0;
            run_overflow   = 1'b0;
            expected_results.delete();
            fail_count     = 0;
            checked        = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CFG_RATE) cfg_rate = i_cfg_data[RATE_W-1:0];
                else if (i_cfg_index == CFG_LIMIT) cfg_late_limit = i_cfg_data[LATE_W-1:0];
            end
            if (i_job_valid && i_job_ready) begin
                p = schedule_job(i_job_data[DL_W-1:0], i_job_data[DL_W+LEN_W-1:DL_W],
                                 i_job_user[0], i_job_last);
                expected_results.insert(expected_results.size(), p);
            end
            if (i_res_valid && i_res_ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: result word with none expected, actual %h", $time,
                             i_res_data);
                    fail_count++;
                end else begin
                    e = expected_results.pop_front();
                    bad = 0;
                    bad += field_differs("feasible", e.feasible, i_res_data[0]);
                    bad += field_differs("late_jobs", e.late_jobs, i_res_data[LATE_W:1]);
                    bad += field_differs("accepted_total", e.total,
                                         i_res_data[LATE_W+TOTAL_W:LATE_W+1]);
                    bad += field_differs("heap_overflow", e.overflow,
                                         i_res_data[LATE_W+TOTAL_W+1]);
                    bad += field_differs("run_end", e.run_end, i_res_last);
                    if (bad != 0) fail_count++;
                    checked++;
                end
            end
        end
        o_pending    = expected_results.size();
        o_fail_count = fail_count;
        o_checked    = checked;
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the late job heap scheduler: directed jobs around
// the budget, swap and failure corners, a run that fills the heap to depth,
// a run that drives the late count past its limit, then random well-formed
// runs mixed with noise under random idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    import ljhs_pkg::*;

    localparam int HEAP_DEPTH    = 1024;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 3000;
    localparam int RANDOM_JOBS   = 540;
    localparam int LIMIT         = 1500000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;

    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata = '0;
    logic [0:0]           s_axis_tuser = '0;
    logic                 s_axis_tlast = 1'b0;

    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [OUT_W-1:0]     m_axis_tdata;
    logic                 m_axis_tlast;

    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DAT_W-1:0] i_cfg_data = '0;

    int                   fail_count;
    int                   pending;
    int                   checked;

    int                   cycles = 0;
    int                   jobs_sent = 0;
    int                   runs_sent = 0;
    int                   reg_writes = 0;
    bit                   tx_burst = 1'b0;
    bit                   rx_burst = 1'b0;
    bit                   hold_req = 1'b0;
    logic [RATE_W-1:0]    cur_rate = 32'd1;

    late_job_heap_scheduler #(
        .HEAP_DEPTH(HEAP_DEPTH)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    ljhs_checker #(
        .HEAP_DEPTH(HEAP_DEPTH)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (s_axis_tvalid),
        .i_job_ready  (s_axis_tready),
        .i_job_data   (s_axis_tdata),
        .i_job_user   (s_axis_tuser),
        .i_job_last   (s_axis_tlast),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .i_res_last   (m_axis_tlast),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic send_job(input logic [DL_W-1:0] dl, input logic [LEN_W-1:0] len,
                            input logic is_first, input logic is_last);
        int   gap;
        logic acc;
        if ($urandom_range(0, 63) == 0) tx_burst = !tx_burst;
        gap = tx_burst ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {len, dl};
        s_axis_tuser  <= is_first;
        s_axis_tlast  <= is_last;
        do begin
            @(negedge i_clk);
            acc = s_axis_tready;
            @(posedge i_clk);
        end while (!acc);
        jobs_sent++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        logic acc;
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do begin
            @(negedge i_clk);
            acc = o_cfg_ready;
            @(posedge i_clk);
        end while (!acc);
        reg_writes++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic settle();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_config(input logic [RATE_W-1:0] rate, input logic [LATE_W-1:0] limit);
        settle();
        write_reg(CFG_RATE, rate);
        write_reg(CFG_LIMIT, CFG_DAT_W'(limit));
        i_cfg_valid <= 1'b0;
        cur_rate = rate;
        @(posedge i_clk);
    endtask

    // nondecreasing deadlines paced near the budget so accepts and late jobs mix
    task automatic send_sched_run(input int n);
        logic [LEN_W-1:0] mask;
        logic [LEN_W-1:0] len;
        longint           dl;
        longint           step;
        case ($urandom_range(0, 3))
            0:       mask = 16'h000F;
            1:       mask = 16'h00FF;
            2:       mask = 16'h0FFF;
            default: mask = 16'hFFFF;
        endcase
        dl = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
            len = LEN_W'($urandom) & mask;
            send_job(DL_W'(dl), len, i == 0, i == n - 1);
            if (cur_rate == 0) step = $urandom_range(0, 3);
            else step = (longint'(len) * $urandom_range(0, 24)) / (16 * longint'(cur_rate))
                        + ($urandom_range(0, 3) == 0);
            dl = dl + step;
            if (dl > 65535) dl = 65535;
        end
        runs_sent++;
    endtask

    task automatic send_noise_run(input int n);
        for (int i = 0; i < n; i++) begin
            send_job(DL_W'($urandom), LEN_W'($urandom), $urandom_range(0, 7) == 0,
                     $urandom_range(0, 7) == 0);
        end
        runs_sent++;
    endtask

    // receiver: random stalls, bursts of back-to-back acceptance, one long hold-off
    initial begin
        int   stall;
        logic acc;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            if ($urandom_range(0, 31) == 0) rx_burst = !rx_burst;
            stall = rx_burst ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do begin
                @(negedge i_clk);
                acc = m_axis_tvalid;
                @(posedge i_clk);
            end while (!acc);
        end
    end

    initial begin
        logic [RATE_W-1:0] r;
        logic [LATE_W-1:0] lim;
        int                start_jobs;
        int                phase;
        int                n;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset values: rate 1, no late job allowed
        send_job(16'd0, 16'd0, 1'b1, 1'b0);
        send_job(16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
        send_job(16'hFFFF, 16'd1, 1'b0, 1'b0);
        send_job(16'hFFFF, 16'd0, 1'b0, 1'b1);

        // rate zero
        set_config(32'd0, 11'd1024);
        send_job(16'd0, 16'd0, 1'b1, 1'b0);
        send_job(16'd5, 16'd7, 1'b0, 1'b0);
        send_job(16'd9, 16'd1, 1'b0, 1'b0);
        send_job(16'd10, 16'd0, 1'b0, 1'b1);

        // swap of the longest job, a late job without swap
        set_config(32'd3, 11'd2);
        send_job(16'd10, 16'd30, 1'b1, 1'b0);
        send_job(16'd12, 16'd20, 1'b0, 1'b0);
        send_job(16'd12, 16'd5, 1'b0, 1'b0);
        send_job(16'd13, 16'd40, 1'b0, 1'b0);
        send_job(16'd13, 16'd1, 1'b0, 1'b0);
        send_job(16'd20, 16'd1, 1'b0, 1'b1);
        send_job(16'd100, 16'd1, 1'b0, 1'b1);
        // deadline order broken
        send_job(16'd50, 16'd10, 1'b1, 1'b0);
        send_job(16'd5, 16'd10, 1'b0, 1'b0);
        send_job(16'd1, 16'd0, 1'b0, 1'b1);

        set_config(32'hFFFF_FFFF, 11'd2047);
        send_job(16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
        send_job(16'd0, 16'hFFFF, 1'b0, 1'b0);
        send_job(16'hFFFF, 16'd0, 1'b0, 1'b1);
        runs_sent += 7;

        // fill the heap to depth, overflow, then late jobs sifting a full heap
        set_config(32'hFFFF_FFFF, 11'd1024);
        for (int i = 0; i < HEAP_DEPTH + 6; i++)
            send_job(16'hFFFF, LEN_W'($urandom), i == 0, 1'b0);
        for (int i = 0; i < 6; i++)
            send_job(16'd0, LEN_W'($urandom_range(1, 65535)), 1'b0, i == 5);
        runs_sent++;

        // late count past a small limit, then frozen until the run ends
        set_config(32'd0, 11'd20);
        for (int i = 0; i < 30; i++)
            send_job(DL_W'($urandom), LEN_W'($urandom_range(1, 65535)), i == 0, i == 29);
        runs_sent++;

        start_jobs = jobs_sent;
        phase = 0;
        while (jobs_sent - start_jobs < RANDOM_JOBS) begin
            case ($urandom_range(0, 6))
                0:       r = 32'd1;
                1:       r = $urandom_range(2, 16);
                2:       r = $urandom_range(17, 1000);
                3:       r = 32'd1 << $urandom_range(0, 31);
                4:       r = $urandom;
                5:       r = 32'hFFFF_FFFF;
                default: r = 32'd0;
            endcase
            case ($urandom_range(0, 4))
                0:       lim = 11'd0;
                1:       lim = LATE_W'($urandom_range(1, 4));
                2:       lim = LATE_W'($urandom_range(5, 40));
                3:       lim = 11'd1024;
                default: lim = LATE_W'($urandom_range(0, 1024));
            endcase
            set_config(r, lim);
            if (phase == 1) begin
                hold_req = 1'b1;
                tx_burst = 1'b1;
                send_sched_run(60);
            end
            repeat ($urandom_range(2, 6)) begin
                if ($urandom_range(0, 6) == 0) begin
                    send_noise_run($urandom_range(1, 20));
                end else begin
                    n = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40)
                                                    : $urandom_range(1, 12);
                    send_sched_run(n);
                end
                if ($urandom_range(0, 9) == 0) wait_drained();
            end
            phase++;
        end

        settle();
        $display("covered %0d jobs in %0d runs, %0d register writes, %0d result words checked",
                 jobs_sent, runs_sent, reg_writes, checked);
        $display("incl. rate zero and all-ones, a full heap, a failing run, a long output stall");
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
